[hdl/plx_pkg.sv]
// Shared types, codes and helpers for the punctuation, identifier and string lexer.
`timescale 1ns / 1ps

package plx_pkg;

    localparam int PLX_POS_BITS = 16;
    localparam int Q_DEPTH      = 4;

    // Token kinds.
    localparam logic [3:0] K_ARROW    = 4'd0;
    localparam logic [3:0] K_DASH     = 4'd1;
    localparam logic [3:0] K_IDENT    = 4'd2;
    localparam logic [3:0] K_STRING   = 4'd3;
    localparam logic [3:0] K_COLON    = 4'd4;
    localparam logic [3:0] K_DCOLON   = 4'd5;
    localparam logic [3:0] K_COMMA    = 4'd6;
    localparam logic [3:0] K_BSLASH   = 4'd7;
    localparam logic [3:0] K_PIPE     = 4'd8;
    localparam logic [3:0] K_LPAREN   = 4'd9;
    localparam logic [3:0] K_RPAREN   = 4'd10;
    localparam logic [3:0] K_LBRACKET = 4'd11;
    localparam logic [3:0] K_RBRACKET = 4'd12;
    localparam logic [3:0] K_LBRACE   = 4'd13;
    localparam logic [3:0] K_RBRACE   = 4'd14;

    // Characters of interest.
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_USCORE   = 8'h5F;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PIPE     = 8'h7C;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] text_len;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
    } t_tok;

    // Tokens caused by one byte: one or two of them.
    typedef struct packed {
        logic two;
        t_tok tok0;
        t_tok tok1;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_push;

    function automatic logic is_word(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_USCORE);
    endfunction

endpackage

[hdl/plx_front.sv]
// Front end: takes bytes, holds the lexer mode and position, and forms token records.
`timescale 1ns / 1ps

module plx_front
    import plx_pkg::*;
#(
    parameter int POS_BITS = PLX_POS_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_in   i_in_item,
    input  logic  i_q_ready,
    output t_push o_push
);

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_COLON = 3'd1;
    localparam logic [2:0] M_DASH  = 3'd2;
    localparam logic [2:0] M_IDENT = 3'd3;
    localparam logic [2:0] M_STR   = 3'd4;

    logic [2:0]          r_mode,  n_mode;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [POS_BITS-1:0] r_len,   n_len;

    logic       accept;
    logic [7:0] c;
    logic       a_v, b_v, f_v, run_idle;
    t_tok       a_tok, b_tok, f_tok;
    logic [1:0] cnt;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (&v) ? v : v + POS_BITS'(1);
    endfunction

    function automatic t_tok mk_tok(input logic [3:0] k, input logic [POS_BITS-1:0] s,
                                    input logic [POS_BITS-1:0] l);
        t_tok t;
        t.kind  = k;
        t.start = 16'(s);
        t.len   = 16'(l);
        return t;
    endfunction

    assign accept     = i_in_valid & i_q_ready;
    assign o_in_ready = i_q_ready;
    assign c          = i_in_item.ch;

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_pos    = sat_inc(r_pos);
        a_v      = 1'b0;
        a_tok    = mk_tok(K_COLON, r_start, '0);
        b_v      = 1'b0;
        b_tok    = mk_tok(K_COMMA, r_pos, '0);
        f_v      = 1'b0;
        f_tok    = mk_tok(K_COLON, r_start, '0);
        run_idle = 1'b0;

        // Pending token held by the current mode.
        case (r_mode)
            M_COLON: begin
                n_mode = M_IDLE;
                a_v    = 1'b1;
                if (c == CH_COLON) begin
                    a_tok = mk_tok(K_DCOLON, r_start, '0);
                end else begin
                    a_tok    = mk_tok(K_COLON, r_start, '0);
                    run_idle = 1'b1;
                end
            end
            M_DASH: begin
                n_mode = M_IDLE;
                a_v    = 1'b1;
                if (c == CH_GT) begin
                    a_tok = mk_tok(K_ARROW, r_start, '0);
                end else begin
                    a_tok    = mk_tok(K_DASH, r_start, '0);
                    run_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_word(c)) begin
                    n_len = sat_inc(r_len);
                end else begin
                    n_mode   = M_IDLE;
                    a_v      = 1'b1;
                    a_tok    = mk_tok(K_IDENT, r_start, r_len);
                    run_idle = 1'b1;
                end
            end
            M_STR: begin
                if (c == CH_QUOTE) begin
                    n_mode = M_IDLE;
                    a_v    = 1'b1;
                    a_tok  = mk_tok(K_STRING, r_start, r_len);
                end else begin
                    n_len = sat_inc(r_len);
                end
            end
            default: begin
                n_mode   = M_IDLE;
                run_idle = 1'b1;
            end
        endcase

        // The byte itself, lexed from the idle mode.
        if (run_idle) begin
            case (c)
                CH_BSLASH:   begin b_v = 1'b1; b_tok = mk_tok(K_BSLASH, r_pos, '0); end
                CH_COMMA:    begin b_v = 1'b1; b_tok = mk_tok(K_COMMA, r_pos, '0); end
                CH_PIPE:     begin b_v = 1'b1; b_tok = mk_tok(K_PIPE, r_pos, '0); end
                CH_LPAREN:   begin b_v = 1'b1; b_tok = mk_tok(K_LPAREN, r_pos, '0); end
                CH_RPAREN:   begin b_v = 1'b1; b_tok = mk_tok(K_RPAREN, r_pos, '0); end
                CH_LBRACKET: begin b_v = 1'b1; b_tok = mk_tok(K_LBRACKET, r_pos, '0); end
                CH_RBRACKET: begin b_v = 1'b1; b_tok = mk_tok(K_RBRACKET, r_pos, '0); end
                CH_LBRACE:   begin b_v = 1'b1; b_tok = mk_tok(K_LBRACE, r_pos, '0); end
                CH_RBRACE:   begin b_v = 1'b1; b_tok = mk_tok(K_RBRACE, r_pos, '0); end
                CH_COLON: begin
                    n_mode = M_COLON; n_start = r_pos; n_len = '0;
                end
                CH_DASH: begin
                    n_mode = M_DASH; n_start = r_pos; n_len = '0;
                end
                CH_QUOTE: begin
                    n_mode = M_STR; n_start = r_pos; n_len = '0;
                end
                default: begin
                    if (is_word(c)) begin
                        n_mode  = M_IDENT;
                        n_start = r_pos;
                        n_len   = POS_BITS'(1);
                    end
                end
            endcase
        end

        // On the last byte, flush what is pending; an open string is dropped.
        if (i_in_item.final_byte) begin
            case (n_mode)
                M_COLON: begin f_v = 1'b1; f_tok = mk_tok(K_COLON, n_start, '0); end
                M_DASH:  begin f_v = 1'b1; f_tok = mk_tok(K_DASH, n_start, '0); end
                M_IDENT: begin f_v = 1'b1; f_tok = mk_tok(K_IDENT, n_start, n_len); end
                default: f_v = 1'b0;
            endcase
            n_mode  = M_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_len   = '0;
        end
    end

    assign cnt = 2'(a_v) + 2'(b_v) + 2'(f_v);

    always_comb begin
        o_push.valid    = accept && (cnt != 2'd0);
        o_push.rec.two  = (cnt == 2'd2);
        if (a_v) begin
            o_push.rec.tok0 = a_tok;
            o_push.rec.tok1 = b_v ? b_tok : f_tok;
        end else if (b_v) begin
            o_push.rec.tok0 = b_tok;
            o_push.rec.tok1 = f_tok;
        end else begin
            o_push.rec.tok0 = f_tok;
            o_push.rec.tok1 = f_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
        end
    end

endmodule

[hdl/plx_queue.sv]
// Short queue of token records between the front end and the emitter.
`timescale 1ns / 1ps

module plx_queue
    import plx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_not_full,
    output logic  o_head_valid,
    output t_rec  o_head
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_rec             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_not_full   = (r_count != CNT_W'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

[hdl/plx_back.sv]
// Emitter: drains token records one token per transaction into the output register.
`timescale 1ns / 1ps

module plx_back
    import plx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_head_valid,
    input  t_rec i_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    logic r_out_valid;
    t_out r_out, n_out;
    logic r_half;
    logic load;
    t_tok sel;

    // r_half is set while the second token of a two-token record is still to go.
    assign load  = i_head_valid && (!r_out_valid || i_out_ready);
    assign sel   = r_half ? i_head.tok1 : i_head.tok0;
    assign o_pop = load && (!i_head.two || r_half);

    always_comb begin
        n_out.token_kind  = sel.kind;
        n_out.start_pos   = sel.start;
        n_out.text_len    = sel.len;
        n_out.last_of_run = !i_head.two || r_half;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_half      <= i_head.two && !r_half;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_half_holds_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_head_valid && i_head.two))
        else $error("second-token flag set without a two-token record at the head");

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("queue popped while empty");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !r_out.last_of_run)
            |=> (r_out_valid && r_out.last_of_run))
        else $error("second token of a run did not follow the first");
`endif

endmodule

[hdl/punctuation_identifier_string_lexer.sv]
// Top level of the streaming punctuation, identifier and string lexer.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_ready   i_in_item  (byte, last-byte flag)
//   output   out        o_out_valid / i_out_ready o_out_item (kind, start, length, last)
//
// One byte is accepted per cycle while the four-entry token queue has room.
// A byte that causes two tokens occupies the output register for both tokens in turn, so the
// sustained rate is one byte per cycle, dropping on two-token bytes or when output stalls.
// The first token of a byte passes through the queue, then the output register.
// Reset is synchronous and active low; it returns the lexer to idle at position zero.
// Output stalls back up through the queue only; the front end stalls when it is full.
`timescale 1ns / 1ps

module punctuation_identifier_string_lexer
    import plx_pkg::*;
#(
    parameter int POS_BITS = PLX_POS_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_item
);

    t_push push;
    logic  q_not_full;
    logic  head_valid;
    t_rec  head;
    logic  pop;

    plx_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_ready  (q_not_full),
        .o_push     (push)
    );

    plx_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_not_full   (q_not_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    plx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule
